>>> design/event_timer_one_comparator_macros.svh
// Assertion macros for the event timer
`ifndef EVENT_TIMER_ONE_COMPARATOR_MACROS_SVH
`define EVENT_TIMER_ONE_COMPARATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define ETOC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("etoc assertion failed");
`define ETOC_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
    else $error("etoc forbidden condition seen");
`else
`define ETOC_ASSERT(lbl, clk, rstn, prop)
`define ETOC_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

>>> design/etoc_pkg.sv
package etoc_pkg;

  // command codes
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;

  // register word offsets
  localparam logic [6:0] OfsCaps    = 7'h00;
  localparam logic [6:0] OfsGenCfg  = 7'h02;
  localparam logic [6:0] OfsCounter = 7'h1E;
  localparam logic [6:0] OfsTimCfg  = 7'h20;
  localparam logic [6:0] OfsCompare = 7'h21;

  // timer config bit positions
  localparam int unsigned BitIntEn    = 2;
  localparam int unsigned BitPeriodic = 3;
  localparam int unsigned BitValSet   = 6;
  localparam int unsigned RouteLsb    = 9;

  localparam int unsigned PeriodW  = 27;
  localparam int unsigned RouteW   = 5;

  localparam logic [31:0]        CapsLow         = 32'h0000_2001;
  localparam logic [PeriodW-1:0] TickPeriodReset = 27'd69841279;
  localparam logic [63:0]        CompareReset    = '1;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  word_offset;
    logic [63:0] write_data;
  } item_t;

  typedef struct packed {
    logic [63:0]       read_data;
    logic              irq_pulse;
    logic [RouteW-1:0] irq_route;
  } result_t;

endpackage

>>> design/etoc_in_reg.sv
module etoc_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  etoc_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output etoc_pkg::item_t item_o
);

  logic            vld_q, vld_d;
  etoc_pkg::item_t item_q;

  assign ready_o = !vld_q || ready_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

>>> design/etoc_core.sv
`include "event_timer_one_comparator_macros.svh"

module etoc_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [etoc_pkg::PeriodW-1:0]    cfg_wdata_i,
  input  logic                            fire_i,
  input  etoc_pkg::item_t                 item_i,
  output etoc_pkg::result_t               res_o
);

  logic                               cnt_en_q, cnt_en_d;
  logic [63:0]                        count_q, count_d;
  logic                               int_en_q, int_en_d;
  logic                               per_q, per_d;
  logic                               vs_q, vs_d;
  logic [etoc_pkg::RouteW-1:0]        route_q, route_d;
  logic [63:0]                        cmp_q, cmp_d;
  logic [63:0]                        period_q, period_d;
  logic [etoc_pkg::PeriodW-1:0]       tick_q;

  logic [63:0] cnt_inc;
  logic [63:0] cmp_adv;
  logic        match;
  logic [63:0] rdata;
  logic        pulse;
  logic        is_tick;

  assign cnt_inc = count_q + 64'd1;
  assign cmp_adv = cmp_q + period_q;
  assign match   = (cnt_inc == cmp_q);
  assign is_tick = (item_i.command == etoc_pkg::CmdTick) && cnt_en_q;

  // register read mux
  always_comb begin
    unique case (item_i.word_offset)
      etoc_pkg::OfsCaps:    rdata = {5'd0, tick_q, etoc_pkg::CapsLow};
      etoc_pkg::OfsGenCfg:  rdata = {63'd0, cnt_en_q};
      etoc_pkg::OfsCounter: rdata = count_q;
      // route 13:9, value-set 6, periodic 3, int enable 2
      etoc_pkg::OfsTimCfg:  rdata = {50'd0, route_q, 2'd0, vs_q, 2'd0, per_q, int_en_q, 2'd0};
      etoc_pkg::OfsCompare: rdata = cmp_q;
      default:              rdata = 64'd0;
    endcase
  end

  always_comb begin
    cnt_en_d = cnt_en_q;
    count_d  = count_q;
    int_en_d = int_en_q;
    per_d    = per_q;
    vs_d     = vs_q;
    route_d  = route_q;
    cmp_d    = cmp_q;
    period_d = period_q;
    pulse    = 1'b0;
    case (item_i.command)
      etoc_pkg::CmdWrite: begin
        unique case (item_i.word_offset)
          etoc_pkg::OfsGenCfg:  cnt_en_d = item_i.write_data[0];
          etoc_pkg::OfsCounter: count_d  = item_i.write_data;
          etoc_pkg::OfsTimCfg: begin
            int_en_d = item_i.write_data[etoc_pkg::BitIntEn];
            per_d    = item_i.write_data[etoc_pkg::BitPeriodic];
            vs_d     = item_i.write_data[etoc_pkg::BitValSet];
            route_d  = item_i.write_data[etoc_pkg::RouteLsb +: etoc_pkg::RouteW];
          end
          etoc_pkg::OfsCompare: begin
            period_d = item_i.write_data;
            if (!per_q || vs_q) begin
              cmp_d = item_i.write_data;
              vs_d  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      etoc_pkg::CmdTick: begin
        if (cnt_en_q) begin
          count_d = cnt_inc;
          if (match) begin
            pulse = int_en_q;
            if (per_q) begin
              cmp_d = cmp_adv;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_en_q <= 1'b0;
      count_q  <= 64'd0;
      int_en_q <= 1'b0;
      per_q    <= 1'b0;
      vs_q     <= 1'b0;
      route_q  <= '0;
      cmp_q    <= etoc_pkg::CompareReset;
      period_q <= 64'd0;
      tick_q   <= etoc_pkg::TickPeriodReset;
    end else begin
      if (fire_i) begin
        cnt_en_q <= cnt_en_d;
        count_q  <= count_d;
        int_en_q <= int_en_d;
        per_q    <= per_d;
        vs_q     <= vs_d;
        route_q  <= route_d;
        cmp_q    <= cmp_d;
        period_q <= period_d;
      end
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
    end
  end

  assign res_o.read_data = (item_i.command == etoc_pkg::CmdRead) ? rdata : 64'd0;
  assign res_o.irq_pulse = pulse;
  assign res_o.irq_route = route_d;

  `ETOC_ASSERT(a_pulse_needs_tick, clk_i, rst_ni,
               fire_i && res_o.irq_pulse |-> is_tick && match && int_en_q)
  `ETOC_ASSERT(a_count_holds_idle, clk_i, rst_ni, !fire_i |=> $stable(count_q))
  `ETOC_ASSERT(a_cmp_holds_idle, clk_i, rst_ni, !fire_i |=> $stable(cmp_q))
  `ETOC_ASSERT_NEVER(a_rd_on_non_read, clk_i, rst_ni,
                     item_i.command != etoc_pkg::CmdRead && res_o.read_data != 64'd0)

endmodule

>>> design/etoc_out_reg.sv
module etoc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  etoc_pkg::result_t res_i,
  output logic              valid_o,
  input  logic              ready_i,
  output etoc_pkg::result_t res_o
);

  logic              vld_q;
  etoc_pkg::result_t res_q;

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

>>> design/event_timer_one_comparator.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+--------------------------------------
// in       | in_valid_i / in_ready_o    | command_i, word_offset_i, write_data_i
// out      | out_valid_o / out_ready_i  | read_data_o, irq_pulse_o, irq_route_o
// cfg      | cfg_we_i (no wait)         | cfg_wdata_i (tick period, fs)
//
// One transaction per clock sustained while out_ready_i is high; the result
// passes the input register, then the result register, before out_valid_o.
// Counter increment, comparator match and periodic advance are one pass of
// logic between the two registers.
// rst_ni is asynchronous, active low; counter 0, comparator all ones.
// A stalled output holds its result; the input register still takes one more.
module event_timer_one_comparator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [6:0]                   word_offset_i,
  input  logic [63:0]                  write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [63:0]                  read_data_o,
  output logic                         irq_pulse_o,
  output logic [etoc_pkg::RouteW-1:0]  irq_route_o,
  input  logic                         cfg_we_i,
  input  logic [etoc_pkg::PeriodW-1:0] cfg_wdata_i
);

  etoc_pkg::item_t   in_item, ex_item;
  etoc_pkg::result_t ex_res, out_res;
  logic              ex_valid, ex_ready;

  assign in_item.command     = command_i;
  assign in_item.word_offset = word_offset_i;
  assign in_item.write_data  = write_data_i;

  etoc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (ex_valid),
    .ready_i (ex_ready),
    .item_o  (ex_item)
  );

  etoc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (ex_valid && ex_ready),
    .item_i      (ex_item),
    .res_o       (ex_res)
  );

  etoc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ex_valid),
    .ready_o (ex_ready),
    .res_i   (ex_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign read_data_o = out_res.read_data;
  assign irq_pulse_o = out_res.irq_pulse;
  assign irq_route_o = out_res.irq_route;

endmodule

>>> tb/testbench.sv
module testbench;

  localparam logic [1:0]                   CmdUnused     = 2'd3;
  localparam logic [6:0]                   OfsUnknown    = 7'd127;
  localparam logic [etoc_pkg::PeriodW-1:0] MaxPeriod     = 27'd100000000;
  localparam int unsigned                  RandomItems   = 600;
  localparam int unsigned                  WatchdogLimit = 2000;

  // Predicts the timer register file and interrupt behavior; holds the
  // results still owed by the block, oldest first.
  class timer_scoreboard;
    logic [etoc_pkg::PeriodW-1:0] tick_period;
    logic                         counter_en;
    logic                         int_en;
    logic                         periodic;
    logic                         val_set;
    logic [etoc_pkg::RouteW-1:0]  route;
    logic [63:0]                  count;
    logic [63:0]                  compare;
    logic [63:0]                  period;
    etoc_pkg::result_t            expected_q[$];
    int unsigned                  accepted;
    int unsigned                  checked;
    int unsigned                  pulses;
    int unsigned                  mismatches;

    function new();
      tick_period = etoc_pkg::TickPeriodReset;
      counter_en  = 1'b0;
      int_en      = 1'b0;
      periodic    = 1'b0;
      val_set     = 1'b0;
      route       = '0;
      count       = '0;
      compare     = etoc_pkg::CompareReset;
      period      = '0;
      accepted    = 0;
      checked     = 0;
      pulses      = 0;
      mismatches  = 0;
    endfunction

    function void note_input(etoc_pkg::item_t it);
      etoc_pkg::result_t r;
      r = '0;
      case (it.command)
        etoc_pkg::CmdRead: begin
          case (it.word_offset)
            etoc_pkg::OfsCaps:    r.read_data = {5'b0, tick_period, etoc_pkg::CapsLow};
            etoc_pkg::OfsGenCfg:  r.read_data = {63'b0, counter_en};
            etoc_pkg::OfsCounter: r.read_data = count;
            etoc_pkg::OfsTimCfg: begin
              r.read_data[etoc_pkg::BitIntEn]                     = int_en;
              r.read_data[etoc_pkg::BitPeriodic]                  = periodic;
              r.read_data[etoc_pkg::BitValSet]                    = val_set;
              r.read_data[etoc_pkg::RouteLsb +: etoc_pkg::RouteW] = route;
            end
            etoc_pkg::OfsCompare: r.read_data = compare;
            default: ;
          endcase
        end
        etoc_pkg::CmdWrite: begin
          case (it.word_offset)
            etoc_pkg::OfsGenCfg:  counter_en = it.write_data[0];
            etoc_pkg::OfsCounter: count = it.write_data;
            etoc_pkg::OfsTimCfg: begin
              int_en   = it.write_data[etoc_pkg::BitIntEn];
              periodic = it.write_data[etoc_pkg::BitPeriodic];
              val_set  = it.write_data[etoc_pkg::BitValSet];
              route    = it.write_data[etoc_pkg::RouteLsb +: etoc_pkg::RouteW];
            end
            etoc_pkg::OfsCompare: begin
              period = it.write_data;
              if (!periodic || val_set) begin
                compare = it.write_data;
                val_set = 1'b0;
              end
            end
            default: ;
          endcase
        end
        etoc_pkg::CmdTick: begin
          if (counter_en) begin
            // increment first, then compare the new value
            count = count + 64'd1;
            if (count == compare) begin
              if (int_en) begin
                r.irq_pulse = 1'b1;
                pulses++;
              end
              if (periodic) compare = compare + period;
            end
          end
        end
        default: ;
      endcase
      r.irq_route = route;
      expected_q.push_back(r);
      accepted++;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(etoc_pkg::result_t got);
      etoc_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result rd=%h irq=%b route=%0d",
                         got.read_data, got.irq_pulse, got.irq_route));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.read_data !== want.read_data)
        report($sformatf("result %0d read_data %h, expected %h",
                         checked, got.read_data, want.read_data));
      if (got.irq_pulse !== want.irq_pulse)
        report($sformatf("result %0d irq_pulse %b, expected %b",
                         checked, got.irq_pulse, want.irq_pulse));
      if (got.irq_route !== want.irq_route)
        report($sformatf("result %0d irq_route %0d, expected %0d",
                         checked, got.irq_route, want.irq_route));
    endtask
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic [1:0]                   command_i     = etoc_pkg::CmdRead;
  logic [6:0]                   word_offset_i = etoc_pkg::OfsCaps;
  logic [63:0]                  write_data_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [63:0]                  read_data_o;
  logic                         irq_pulse_o;
  logic [etoc_pkg::RouteW-1:0]  irq_route_o;
  logic                         cfg_we_i      = 1'b0;
  logic [etoc_pkg::PeriodW-1:0] cfg_wdata_i   = etoc_pkg::TickPeriodReset;

  timer_scoreboard sb = new();
  bit              calm = 1'b0;
  int unsigned     quiet_cycles = 0;
  int unsigned     cfg_writes = 0;
  logic [6:0]      known_ofs[5] = '{etoc_pkg::OfsCaps, etoc_pkg::OfsGenCfg,
                                    etoc_pkg::OfsCounter, etoc_pkg::OfsTimCfg,
                                    etoc_pkg::OfsCompare};

  event_timer_one_comparator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .word_offset_i (word_offset_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o),
    .irq_pulse_o   (irq_pulse_o),
    .irq_route_o   (irq_route_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 14);
  end

  // transaction monitor and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_input({command_i, word_offset_i, write_data_i});
      if (out_valid_o && out_ready_i)
        sb.check_result({read_data_o, irq_pulse_o, irq_route_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [6:0] ofs,
                           input logic [63:0] data);
    int unsigned seen;
    while (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    seen = sb.accepted;
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    word_offset_i <= ofs;
    write_data_i  <= data;
    do @(negedge clk_i); while (sb.accepted == seen);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // period register may only change with nothing in flight
  task automatic write_period(input logic [etoc_pkg::PeriodW-1:0] value);
    drain();
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= value;
    sb.tick_period = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCaps, '1);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsGenCfg, '0);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsTimCfg, '0);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCompare, '0);
    send_item(etoc_pkg::CmdTick, etoc_pkg::OfsCounter, '1);   // counter still disabled
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCounter, '0);
    send_item(etoc_pkg::CmdRead, OfsUnknown, '1);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCaps, '1);     // read-only, dropped
    send_item(etoc_pkg::CmdWrite, OfsUnknown, '1);
    send_item(CmdUnused, etoc_pkg::OfsCounter, '1);
    write_period(27'd1);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCaps, '0);
    write_period(MaxPeriod);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCaps, '0);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsGenCfg, '1);
    // irq, periodic, value-set, route 31
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsTimCfg, '1);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCompare, '1);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCounter, 64'hFFFF_FFFF_FFFF_FFFD);
    send_item(etoc_pkg::CmdTick, etoc_pkg::OfsCaps, '0);
    // match at all ones, comparator wraps
    send_item(etoc_pkg::CmdTick, etoc_pkg::OfsCaps, '0);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCompare, '0);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsTimCfg, 64'h8);    // periodic, irq off
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCompare, 64'd5);   // period only
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCounter, 64'hFFFF_FFFF_FFFF_FFFD);
    // silent match, periodic advance wraps
    send_item(etoc_pkg::CmdTick, etoc_pkg::OfsCaps, '0);
    send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCompare, '0);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsGenCfg, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(etoc_pkg::CmdTick, etoc_pkg::OfsCaps, '0);
  endtask

  // Program a timer and walk the counter toward, and possibly past, the comparator.
  task automatic arm_match();
    logic [63:0] tcfg;
    logic [63:0] cval;
    int unsigned lead;
    int unsigned steps;
    tcfg = {$urandom, $urandom};
    tcfg[etoc_pkg::BitIntEn] = ($urandom_range(3) != 0);
    case ($urandom_range(3))
      0: cval = {$urandom, $urandom};
      1: cval = 64'($urandom_range(1, 8));
      2: cval = '1 - 64'($urandom_range(0, 8));
      default: cval = 64'($urandom_range(0, 40));
    endcase
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsGenCfg, {$urandom, $urandom} | 64'd1);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsTimCfg, tcfg);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCompare, cval);
    if ($urandom_range(3) == 0)
      send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCompare, 64'($urandom_range(1, 6)));
    lead = $urandom_range(1, 6);
    send_item(etoc_pkg::CmdWrite, etoc_pkg::OfsCounter, sb.compare - 64'(lead));
    steps = lead + $urandom_range(0, 10);
    repeat (steps) begin
      if ($urandom_range(4) == 0)
        send_item(etoc_pkg::CmdRead, known_ofs[$urandom_range(4)], {$urandom, $urandom});
      else
        send_item(etoc_pkg::CmdTick, 7'($urandom), {$urandom, $urandom});
    end
  endtask

  task automatic send_noise();
    logic [6:0] ofs;
    repeat ($urandom_range(1, 5)) begin
      ofs = ($urandom_range(1) == 0) ? known_ofs[$urandom_range(4)] : 7'($urandom);
      send_item(2'($urandom_range(3)), ofs, {$urandom, $urandom});
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned done;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    random_start = sb.accepted;
    done = 0;
    while (done < RandomItems) begin
      calm = (done >= 200 && done < 320);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: arm_match();
        6, 7: send_noise();
        8: begin
          repeat ($urandom_range(1, 4))
            send_item(etoc_pkg::CmdRead, known_ofs[$urandom_range(4)],
                      {$urandom, $urandom});
        end
        default: begin
          case ($urandom_range(2))
            0: write_period(27'd1);
            1: write_period(MaxPeriod);
            default: write_period(27'($urandom_range(1, 100000000)));
          endcase
          send_item(etoc_pkg::CmdRead, etoc_pkg::OfsCaps, {$urandom, $urandom});
        end
      endcase
      done = sb.accepted - random_start;
    end
    calm = 1'b0;

    drain();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d register and tick transactions over %0d tick period writes.",
             sb.accepted, cfg_writes);
    $display("%0d results compared, %0d interrupt pulses expected, %0d mismatches.",
             sb.checked, sb.pulses, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/etoc_pkg.sv
design/etoc_in_reg.sv
design/etoc_core.sv
design/etoc_out_reg.sv
design/event_timer_one_comparator.sv
tb/testbench.sv
